// ===== hw/rtl/y2a_pkg.sv =====
// ============================================================================
// y2a_pkg: shared types and constants for the 4:2:2 tile to ARGB converter
// Holds the register index codes, the Q16 conversion coefficients, the group
// record passed from the stream parser to the pixel stage, and the clamp.
// ============================================================================
package y2a_pkg;

  // Configuration register width and index codes.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 1'b0,
    CFG_LINE_COUNT = 1'b1
  } y2a_cfg_idx_e;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd256;
  localparam logic [CFG_W-1:0] LINE_COUNT_RST = 13'd256;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_LINES_DEF = 4096;

  // Chroma terms are held in 26 signed bits; adding the shifted luma takes one more.
  localparam int TERM_W = 26;
  localparam int SUM_W  = 27;

  // Full-range coefficients in Q16, rounded to nearest.
  localparam logic signed [TERM_W-1:0] K_R_CR = 26'sd91881;
  localparam logic signed [TERM_W-1:0] K_G_CB = 26'sd22554;
  localparam logic signed [TERM_W-1:0] K_G_CR = 26'sd46802;
  localparam logic signed [TERM_W-1:0] K_B_CB = 26'sd116130;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // One complete group: both lumas plus the precomputed chroma terms.
  typedef struct packed {
    logic                     valid;
    logic                     eot;
    logic [7:0]               y1;
    logic [7:0]               y2;
    logic signed [TERM_W-1:0] b_term;
    logic signed [TERM_W-1:0] g_term;
    logic signed [TERM_W-1:0] r_term;
  } y2a_grp_t;

  // Negative sums give 0, sums of 256.0 or more give 255, else floor.
  function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (|s[SUM_W-2:24]) begin
      r = 8'd255;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/y2a_if.sv =====
// ============================================================================
// y2a_if: valid/ready stream interfaces of the converter
// A byte stream for the packed tile data and a pixel stream for the results.
// ============================================================================
interface y2a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface y2a_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       last_of_pair;
  logic       end_of_tile;

  modport source (output valid, output blue, output green, output red, output alpha,
                  output last_of_pair, output end_of_tile, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input last_of_pair, input end_of_tile, output ready);
endinterface

// ===== hw/rtl/y2a_parse.sv =====
// ============================================================================
// y2a_parse: byte stream parser and chroma multiplier stage
// Tracks the group byte, row padding and row counters, and on each Cr byte
// registers a group record with the three chroma products.
// ============================================================================
module y2a_parse #(
  parameter int MAX_WIDTH = y2a_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LINES = y2a_pkg::MAX_LINES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [y2a_pkg::CFG_W-1:0] line_width_i,
  input  logic [y2a_pkg::CFG_W-1:0] line_count_i,
  y2a_byte_if.sink                  byte_i,
  output y2a_pkg::y2a_grp_t         grp_o,
  input  logic                      grp_pop_i
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int LW  = $clog2(MAX_LINES + 1);
  localparam int WL  = (WW > LW) ? WW : LW;
  localparam int CW  = ((WL > y2a_pkg::CFG_W) ? WL : y2a_pkg::CFG_W) + 1;

  typedef enum logic [4:0] {
    S_Y1  = 5'b00001,
    S_Y2  = 5'b00010,
    S_CB  = 5'b00100,
    S_CR  = 5'b01000,
    S_PAD = 5'b10000
  } y2a_state_e;

  y2a_state_e state_q, state_d;
  logic [7:0]    y1_q, y1_d, y2_q, y2_d, cb_q, cb_d;
  logic [WW-1:0] pair_q, pair_d, pad_q, pad_d;
  logic [LW-1:0] row_q, row_d;
  y2a_pkg::y2a_grp_t grp_q, grp_d;

  logic [CW-1:0] w_ext, l_ext, eff_w, eff_l;
  logic [CW-1:0] pair_next, pad_next, row_next;
  logic          row_end, row_last, pad_done, accept, grp_load;
  logic signed [8:0]                  dcb, dcr;
  logic signed [y2a_pkg::TERM_W-1:0]  xcb, xcr;

  // Effective limits, saturated to the supported ranges.
  assign w_ext = CW'(line_width_i);
  assign l_ext = CW'(line_count_i);

  always_comb begin
    priority if (w_ext < CW'(2)) begin
      eff_w = CW'(2);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    priority if (l_ext < CW'(1)) begin
      eff_l = CW'(1);
    end else if (l_ext > CW'(MAX_LINES)) begin
      eff_l = CW'(MAX_LINES);
    end else begin
      eff_l = l_ext;
    end
  end

  assign pair_next = CW'(pair_q) + CW'(1);
  assign pad_next  = CW'(pad_q) + CW'(1);
  assign row_next  = CW'(row_q) + CW'(1);
  assign row_end   = pair_next >= (eff_w >> 1);
  assign row_last  = row_next >= eff_l;
  assign pad_done  = pad_next >= eff_w;

  // A Cr byte needs the group register; every other byte is always taken.
  assign byte_i.ready = !((state_q == S_CR) && grp_q.valid);
  assign accept       = byte_i.valid && byte_i.ready;
  assign grp_load     = accept && (state_q == S_CR);

  assign dcb = $signed({1'b0, cb_q}) - 9'sd128;
  assign dcr = $signed({1'b0, byte_i.data_byte}) - 9'sd128;
  assign xcb = y2a_pkg::TERM_W'(dcb);
  assign xcr = y2a_pkg::TERM_W'(dcr);

  always_comb begin
    state_d = state_q;
    y1_d    = y1_q;
    y2_d    = y2_q;
    cb_d    = cb_q;
    pair_d  = pair_q;
    pad_d   = pad_q;
    row_d   = row_q;
    grp_d   = grp_q;
    if (grp_pop_i) begin
      grp_d.valid = 1'b0;
    end
    if (accept) begin
      unique case (state_q)
        S_Y1: begin
          y1_d    = byte_i.data_byte;
          state_d = S_Y2;
        end
        S_Y2: begin
          y2_d    = byte_i.data_byte;
          state_d = S_CB;
        end
        S_CB: begin
          cb_d    = byte_i.data_byte;
          state_d = S_CR;
        end
        S_CR: begin
          grp_d.valid  = 1'b1;
          grp_d.eot    = row_end && row_last;
          grp_d.y1     = y1_q;
          grp_d.y2     = y2_q;
          grp_d.b_term = y2a_pkg::K_B_CB * xcb;
          grp_d.g_term = y2a_pkg::TERM_W'(0) - y2a_pkg::K_G_CB * xcb
                         - y2a_pkg::K_G_CR * xcr;
          grp_d.r_term = y2a_pkg::K_R_CR * xcr;
          if (row_end) begin
            pair_d  = '0;
            pad_d   = '0;
            state_d = S_PAD;
          end else begin
            pair_d  = pair_next[WW-1:0];
            state_d = S_Y1;
          end
        end
        S_PAD: begin
          if (pad_done) begin
            pad_d   = '0;
            state_d = S_Y1;
            row_d   = row_last ? '0 : row_next[LW-1:0];
          end else begin
            pad_d = pad_next[WW-1:0];
          end
        end
        default: begin
          state_d = S_Y1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_Y1;
      y1_q    <= '0;
      y2_q    <= '0;
      cb_q    <= '0;
      pair_q  <= '0;
      pad_q   <= '0;
      row_q   <= '0;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      y1_q    <= y1_d;
      y2_q    <= y2_d;
      cb_q    <= cb_d;
      pair_q  <= pair_d;
      pad_q   <= pad_d;
      row_q   <= row_d;
      grp_q   <= grp_d;
    end
  end

  assign grp_o = grp_q;

  // A pending group is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_load |-> !grp_q.valid)
    else $error("group register overwritten while still pending");

  // The padding counter is only live while padding is consumed.
  a_pad_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_PAD) |-> (pad_q == '0))
    else $error("padding count nonzero outside padding");

  // The pixel stage only releases a group that is actually held.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_pop_i |-> grp_q.valid)
    else $error("group released while none is held");

endmodule

// ===== hw/rtl/y2a_pixel.sv =====
// ============================================================================
// y2a_pixel: pixel serializer, luma add, clamp and output register
// Turns each group record into two pixels, one per cycle unless pix_o stalls, into a single
// output register that stays full under back-pressure.
// ============================================================================
module y2a_pixel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  y2a_pkg::y2a_grp_t grp_i,
  output logic              grp_pop_o,
  y2a_pix_if.source         pix_o
);

  logic       sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  logic       load;
  logic [7:0] y_sel;
  logic signed [y2a_pkg::SUM_W-1:0] yy, b_sum, g_sum, r_sum;
  logic [7:0] blue_q, green_q, red_q;
  logic       last_q, eot_q;

  assign load      = grp_i.valid && (!out_valid_q || pix_o.ready);
  assign grp_pop_o = load && sel_q;

  assign y_sel = sel_q ? grp_i.y2 : grp_i.y1;
  assign yy    = $signed({3'b000, y_sel, 16'h0000});
  assign b_sum = yy + y2a_pkg::SUM_W'(grp_i.b_term);
  assign g_sum = yy + y2a_pkg::SUM_W'(grp_i.g_term);
  assign r_sum = yy + y2a_pkg::SUM_W'(grp_i.r_term);

  always_comb begin
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    if (load) begin
      sel_d       = !sel_q;
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blue_q  <= y2a_pkg::clamp_q16(b_sum);
      green_q <= y2a_pkg::clamp_q16(g_sum);
      red_q   <= y2a_pkg::clamp_q16(r_sum);
      last_q  <= sel_q;
      eot_q   <= sel_q && grp_i.eot;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.blue         = blue_q;
  assign pix_o.green        = green_q;
  assign pix_o.red          = red_q;
  assign pix_o.alpha        = y2a_pkg::ALPHA_OPAQUE;
  assign pix_o.last_of_pair = last_q;
  assign pix_o.end_of_tile  = eot_q;

  // While a first pixel is shown, its group is still held for the second.
  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> grp_i.valid)
    else $error("group released before its second pixel");

  // The tile end flag only appears on the second pixel of a group.
  a_eot_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!eot_q || last_q))
    else $error("end of tile flagged on a first pixel");

  // The output never drains between the two pixels of one group.
  a_rise_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> !last_q)
    else $error("second pixel shown without its first one");

endmodule

// ===== hw/rtl/ycbcr422_tile_to_argb.sv =====
// ============================================================================
// ycbcr422_tile_to_argb: packed 4:2:2 tile stream to 32-bit ARGB pixels
// Top level: configuration registers, stream parser and pixel stage.
// ============================================================================
// The block takes one tile byte per cycle on byte_i in groups of Y1, Y2, Cb,
// Cr and returns two ARGB pixels per group on pix_o using the full-range JPEG
// equations in signed Q16, each channel clamped to 0..255 and alpha fixed at
// 255. A row holds floor(line_width/2) groups followed by line_width padding
// bytes that produce nothing; the second pixel of the last group of the last
// row carries end_of_tile, after which the row count wraps for the next tile.
// Input bytes are taken every cycle; the Cr byte is the only one that can be
// held back, and only while the previous group still waits for its second
// pixel to enter the output register. Each pixel passes the group register
// and then the single output register, the second once the first is taken;
// four bytes give two pixels, so the sustained rate is one byte per cycle
// while pix_o is not stalled. Register values outside the supported range
// are saturated to 2..MAX_WIDTH pixels and 1..MAX_LINES rows. The user writes
// registers through cfg_we_i, cfg_idx_i (0 is line_width, 1 is line_count) and
// cfg_data_i only while the block is idle, which the block does not enforce.
module ycbcr422_tile_to_argb #(
  parameter int MAX_WIDTH = y2a_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LINES = y2a_pkg::MAX_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [y2a_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [y2a_pkg::CFG_W-1:0]     cfg_data_i,
  y2a_byte_if.sink                      byte_i,
  y2a_pix_if.source                     pix_o
);

  logic [y2a_pkg::CFG_W-1:0] line_width_q, line_width_d;
  logic [y2a_pkg::CFG_W-1:0] line_count_q, line_count_d;
  y2a_pkg::y2a_grp_t         grp;
  logic                      grp_pop;

  // Register file: two plain write-only registers.
  always_comb begin
    line_width_d = line_width_q;
    line_count_d = line_count_q;
    if (cfg_we_i) begin
      unique case (y2a_pkg::y2a_cfg_idx_e'(cfg_idx_i))
        y2a_pkg::CFG_LINE_WIDTH: line_width_d = cfg_data_i;
        y2a_pkg::CFG_LINE_COUNT: line_count_d = cfg_data_i;
        default: begin
          line_width_d = line_width_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= y2a_pkg::LINE_WIDTH_RST;
      line_count_q <= y2a_pkg::LINE_COUNT_RST;
    end else begin
      line_width_q <= line_width_d;
      line_count_q <= line_count_d;
    end
  end

  // Parser: group assembly, padding and row tracking, chroma products.
  y2a_parse #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .line_count_i (line_count_q),
    .byte_i       (byte_i),
    .grp_o        (grp),
    .grp_pop_i    (grp_pop)
  );

  // Pixel stage: adds luma, clamps, and serializes the pair.
  y2a_pixel u_pixel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .grp_i     (grp),
    .grp_pop_o (grp_pop),
    .pix_o     (pix_o)
  );

endmodule

// ===== test/ycbcr422_tile_to_argb_tb.sv =====
// ============================================================================
// ycbcr422_tile_to_argb_tb: self-checking testbench of the 4:2:2 tile converter
// Streams tile bytes into the converter, predicts every ARGB pixel from its own
// model of the group parser, row padding and tile counters, and compares each
// pixel on the output stream field by field, across several register settings
// and with random gaps on the byte stream and random stalls on the pixel stream.
// ============================================================================
module ycbcr422_tile_to_argb_tb;

  // Longest run of cycles with no item moving on either stream before the run
  // is declared hung. A correct run never comes close: the longest quiet
  // stretch is a register update pause plus a run of stalls on the pixel stream.
  localparam int QUIET_LIMIT  = 4000;
  // Cycles waited after the last pixel has arrived; by then the converter holds
  // nothing in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 40;

  // One expected or observed output pixel.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last_of_pair;
    logic       end_of_tile;
  } argb_pixel_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [y2a_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [y2a_pkg::CFG_W-1:0]     cfg_data;

  y2a_byte_if byte_if ();
  y2a_pix_if  pix_if ();

  ycbcr422_tile_to_argb dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .byte_i     (byte_if),
    .pix_o      (pix_if)
  );

  // Idling controls, in percent per cycle.
  int unsigned gap_pct;
  int unsigned stall_pct;

  // Run statistics and the error tally.
  int unsigned err_cnt;
  int unsigned bytes_sent;
  int unsigned pixels_checked;
  int unsigned tiles_seen;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  // Pixels predicted but not yet seen on the output, oldest first.
  argb_pixel_t pending_pixels[$];

  // Predicted register contents and parser state, all as after reset.
  logic [y2a_pkg::CFG_W-1:0] width_reg   = y2a_pkg::LINE_WIDTH_RST;
  logic [y2a_pkg::CFG_W-1:0] count_reg   = y2a_pkg::LINE_COUNT_RST;
  logic [1:0]                grp_phase   = '0;
  logic [7:0]                luma_a      = '0;
  logic [7:0]                luma_b      = '0;
  logic [7:0]                cb_hold     = '0;
  int unsigned               pairs_done  = 0;
  bit                        in_padding  = 1'b0;
  int unsigned               pads_seen   = 0;
  int unsigned               rows_done   = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Out-of-range register values saturate to the supported range.
  function automatic int unsigned pixels_per_row();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > y2a_pkg::MAX_WIDTH_DEF) w = y2a_pkg::MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned rows_per_tile();
    int unsigned n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > y2a_pkg::MAX_LINES_DEF) n = y2a_pkg::MAX_LINES_DEF;
    return n;
  endfunction

  // A Q16 channel sum below zero gives 0, one at or above 256.0 gives 255,
  // anything else is floored to its integer part.
  function automatic logic [7:0] channel_from_q16(input int signed sum);
    if (sum < 0) return 8'd0;
    if (sum >= 256 * 65536) return 8'd255;
    return sum[23:16];
  endfunction

  // Full-range JPEG conversion of one pixel, with its flags, into the queue.
  task automatic queue_pixel(input logic [7:0] luma, input logic [7:0] cb,
                             input logic [7:0] cr, input logic last,
                             input logic eot);
    int signed   y_q16;
    int signed   d_cb;
    int signed   d_cr;
    argb_pixel_t px;
    y_q16 = int'(luma) * 65536;
    d_cb  = int'(cb) - 128;
    d_cr  = int'(cr) - 128;
    px.blue         = channel_from_q16(y_q16 + 116130 * d_cb);
    px.green        = channel_from_q16(y_q16 - 22554 * d_cb - 46802 * d_cr);
    px.red          = channel_from_q16(y_q16 + 91881 * d_cr);
    px.alpha        = 8'd255;
    px.last_of_pair = last;
    px.end_of_tile  = eot;
    pending_pixels.push_back(px);
  endtask

  // Advances the parser by one accepted byte. Padding bytes and the first
  // three bytes of a group produce nothing; the Cr byte produces both pixels.
  // Limits are compared with "reached or passed", so a row or tile that is
  // already beyond a freshly shrunk limit closes at its next boundary.
  task automatic advance_tile_parser(input logic [7:0] value);
    int unsigned w;
    int unsigned lines;
    bit          row_end;
    bit          tile_end;
    w     = pixels_per_row();
    lines = rows_per_tile();
    if (in_padding) begin
      pads_seen++;
      if (pads_seen >= w) begin
        pads_seen  = 0;
        in_padding = 1'b0;
        rows_done  = (rows_done + 1 >= lines) ? 0 : rows_done + 1;
      end
    end else begin
      case (grp_phase)
        2'd0: begin
          luma_a    = value;
          grp_phase = 2'd1;
        end
        2'd1: begin
          luma_b    = value;
          grp_phase = 2'd2;
        end
        2'd2: begin
          cb_hold   = value;
          grp_phase = 2'd3;
        end
        default: begin
          row_end  = (pairs_done + 1 >= w / 2);
          tile_end = row_end && (rows_done + 1 >= lines);
          queue_pixel(luma_a, cb_hold, value, 1'b0, 1'b0);
          queue_pixel(luma_b, cb_hold, value, 1'b1, tile_end);
          grp_phase = 2'd0;
          if (row_end) begin
            pairs_done = 0;
            in_padding = 1'b1;
            pads_seen  = 0;
          end else begin
            pairs_done++;
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS) begin
        $display("%0t: pixel %0d %s mismatch, expected %0d, got %0d",
                 $time, pixels_checked, field, want, got);
      end
    end
  endtask

  task automatic check_pixel();
    argb_pixel_t want;
    if (pending_pixels.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS) begin
        $display("%0t: unexpected pixel, expected none, got B%0d G%0d R%0d A%0d L%0b E%0b",
                 $time, pix_if.blue, pix_if.green, pix_if.red, pix_if.alpha,
                 pix_if.last_of_pair, pix_if.end_of_tile);
      end
    end else begin
      want = pending_pixels.pop_front();
      check_field("blue", want.blue, pix_if.blue);
      check_field("green", want.green, pix_if.green);
      check_field("red", want.red, pix_if.red);
      check_field("alpha", want.alpha, pix_if.alpha);
      check_field("last_of_pair", {7'd0, want.last_of_pair},
                  {7'd0, pix_if.last_of_pair});
      check_field("end_of_tile", {7'd0, want.end_of_tile},
                  {7'd0, pix_if.end_of_tile});
      if (want.end_of_tile) tiles_seen++;
    end
    pixels_checked++;
  endtask

  // Everything is sampled at the rising edge, before the edge's own updates
  // land. Outputs are checked before the new byte is predicted; a byte's
  // pixels can never leave in the cycle it is taken, so the order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          y2a_pkg::CFG_LINE_WIDTH: width_reg = cfg_data;
          y2a_pkg::CFG_LINE_COUNT: count_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) check_pixel();
      if (byte_if.valid && byte_if.ready) advance_tile_parser(byte_if.data_byte);
    end
  end

  // Random backpressure on the pixel stream.
  always @(posedge clk) begin
    pix_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: the run is hung when nothing moves on either stream for too long.
  always @(posedge clk) begin
    if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it is taken. A random number
  // of idle cycles may come first; valid is only ever set once per edge.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < gap_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Half of the bytes are the extreme codes, which drive the clamps hardest.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(pick_byte());
  endtask

  // Stops offering bytes and waits until every predicted pixel has arrived.
  // With settle set it then also waits out DRAIN_CYCLES before it returns.
  task automatic wait_drained(input bit settle);
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    if (settle) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges; only called while idle.
  task automatic set_tile_shape(input logic [y2a_pkg::CFG_W-1:0] width,
                                input logic [y2a_pkg::CFG_W-1:0] count);
    cfg_we   <= 1'b1;
    cfg_idx  <= y2a_pkg::CFG_LINE_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cfg_idx  <= y2a_pkg::CFG_LINE_COUNT;
    cfg_data <= count;
    @(posedge clk);
    cfg_we   <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic set_idling(input int unsigned gap, input int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked groups under the reset shape: all bytes zero, all bytes 255, and
  // the chroma corners that push each channel past both ends of its clamp.
  task automatic test_conversion_extremes();
    logic [7:0] groups[6][4];
    groups = '{'{8'd0, 8'd0, 8'd0, 8'd0},
               '{8'd255, 8'd255, 8'd255, 8'd255},
               '{8'd0, 8'd255, 8'd255, 8'd0},
               '{8'd255, 8'd0, 8'd0, 8'd255},
               '{8'd128, 8'd127, 8'd128, 8'd128},
               '{8'd16, 8'd235, 8'd90, 8'd240}};
    set_idling(0, 0);
    foreach (groups[g, b]) send_byte(groups[g][b]);
    wait_drained(1'b1);
  endtask

  // Register values at and beyond both ends. The reset test left the parser
  // in the middle of a long row, so the first shrink also closes that row at
  // its next group. The saturated shapes only run a few rows or groups, and a
  // final narrow shape closes the open row so later tests start aligned.
  task automatic test_register_limits();
    set_idling(0, 0);
    set_tile_shape(13'd0, 13'd0);      // both saturate up: 2 pixels, 1 row
    send_random(4 + 2 + 2 * 6);
    wait_drained(1'b1);
    set_tile_shape(13'd1, 13'd1);
    send_random(2 * 6);
    wait_drained(1'b1);
    set_tile_shape(13'd3, 13'd2);      // odd width: one group, three pad bytes
    send_random(4 * 7);
    wait_drained(1'b1);
    set_tile_shape(13'd2, 13'h1FFF);   // row count saturates to the maximum
    send_random(6 * 6);
    wait_drained(1'b1);
    set_tile_shape(13'h1FFF, 13'd1);   // width saturates: part of a wide row
    send_random(16 * 4);
    wait_drained(1'b1);
    set_tile_shape(13'd2, 13'd1);      // closes the wide row and the tile
    send_random(4 + 2);
    wait_drained(1'b1);
  endtask

  // Shrinking the limits while a row or a tile is under way.
  task automatic test_limit_shrink();
    set_idling(31, 31);
    set_tile_shape(13'd10, 13'd3);
    send_random(5 * 4 + 6);            // a full row and six of its ten pad bytes
    wait_drained(1'b1);
    set_tile_shape(13'd4, 13'd3);      // padding already past the new width
    send_random(1);
    wait_drained(1'b1);
    set_tile_shape(13'd10, 13'd3);
    send_random(3 * 4);
    wait_drained(1'b1);
    set_tile_shape(13'd2, 13'd3);      // groups already past the new row length
    send_random(4 + 2);
    wait_drained(1'b1);
    set_tile_shape(13'd2, 13'd8);
    send_random(5 * 6);
    wait_drained(1'b1);
    set_tile_shape(13'd2, 13'd2);      // rows already past the new tile height
    send_random(2 * 6);
    wait_drained(1'b1);
  endtask

  // Random streams on small random shapes under each idling mix. Halfway
  // through each the byte stream holds off until the output has caught up.
  task automatic test_random_stream();
    int unsigned gaps[4]   = '{0, 46, 0, 31};
    int unsigned stalls[4] = '{0, 0, 46, 31};
    for (int m = 0; m < 4; m++) begin
      set_idling(gaps[m], stalls[m]);
      set_tile_shape(13'($urandom_range(11, 2)), 13'($urandom_range(4, 1)));
      send_random(155);
      wait_drained(1'b0);
      send_random(155);
      wait_drained(1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and sequence
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = y2a_pkg::CFG_LINE_WIDTH;
    cfg_data          = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    pix_if.ready      = 1'b0;
    err_cnt           = 0;
    bytes_sent        = 0;
    pixels_checked    = 0;
    tiles_seen        = 0;
    reg_writes        = 0;
    quiet_cycles      = 0;
    set_idling(0, 0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_conversion_extremes();
    test_register_limits();
    test_limit_shrink();
    test_random_stream();

    wait_drained(1'b1);
    if (pending_pixels.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
    end

    $display("Sent %0d tile bytes and checked %0d pixels across %0d tile ends.",
             bytes_sent, pixels_checked, tiles_seen);
    $display("Made %0d register writes, saturated shapes and mid-tile shrinks included.",
             reg_writes);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
